@@ design/assert_macros.svh @@
// Assertion macros shared by the range max-XOR trie RTL.
// Each macro wraps one concurrent assertion clocked on i_clk, held off in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Implication from a trigger to a consequence in the same cycle.
`define ASSERT_IMPL(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cons)) \
        else $error(msg);

// Implication from a trigger to a consequence in the next cycle.
`define ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

@@ design/rmxt_pkg.sv @@
// Shared types and constants of the range max-XOR trie block.
// No dependencies; each module file refers to it by scoped names.
`timescale 1ns / 1ps

package rmxt_pkg;

    localparam int CAPACITY   = 1024;
    localparam int VALUE_BITS = 31;
    localparam int RANGE_W    = 11;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 2;

    localparam int NODES_PER_VALUE = VALUE_BITS + 1;
    localparam int POOL_NODES      = CAPACITY * NODES_PER_VALUE;
    localparam int PTR_W           = $clog2(POOL_NODES + 1);
    localparam int NODE_AW         = $clog2(POOL_NODES);
    localparam int STORE_W         = $clog2(CAPACITY + 1);
    localparam int ROOT_AW         = $clog2(CAPACITY);
    localparam int TALLY_W         = STORE_W;
    localparam int LEVEL_W         = $clog2(VALUE_BITS);

    localparam int FIRST_LSB = VALUE_BITS;
    localparam int LAST_LSB  = VALUE_BITS + RANGE_W;
    localparam int IN_DATA_W = ((VALUE_BITS + 2 * RANGE_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((VALUE_BITS + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 2'd0,
        MODE_QUERY  = 2'd1,
        MODE_CLEAR  = 2'd2
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT_A,
        ST_ROOT_B,
        ST_WALK,
        ST_LEAF,
        ST_FINISH
    } t_state;

    // A node keeps both child pointers and the tally under each child.
    typedef struct packed {
        logic [PTR_W-1:0]   c0;
        logic [PTR_W-1:0]   c1;
        logic [TALLY_W-1:0] t0;
        logic [TALLY_W-1:0] t1;
    } t_node;

    // Result of one trie level step.
    typedef struct packed {
        logic [PTR_W-1:0] ptr_a;
        logic [PTR_W-1:0] ptr_b;
        logic             res_bit;
        t_node            wr_word;
    } t_step;

endpackage

@@ design/rmxt_node_mem.sv @@
// Node pool of the trie: one write port, two registered read ports.
// Pointer zero is the null node and reads as all zeros. Depends on rmxt_pkg.
`timescale 1ns / 1ps

module rmxt_node_mem (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [rmxt_pkg::PTR_W-1:0] i_wr_ptr,
    input  rmxt_pkg::t_node            i_wr_word,
    input  logic [rmxt_pkg::PTR_W-1:0] i_rd_ptr_a,
    input  logic [rmxt_pkg::PTR_W-1:0] i_rd_ptr_b,
    output rmxt_pkg::t_node            o_rd_word_a,
    output rmxt_pkg::t_node            o_rd_word_b
);

    rmxt_pkg::t_node r_mem [rmxt_pkg::POOL_NODES];
    rmxt_pkg::t_node r_rd_a;
    rmxt_pkg::t_node r_rd_b;
    logic            r_null_a;
    logic            r_null_b;

    // Node n lives at address n-1.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[rmxt_pkg::NODE_AW'(i_wr_ptr - 1'b1)] <= i_wr_word;
        end
        r_rd_a   <= r_mem[rmxt_pkg::NODE_AW'(i_rd_ptr_a - 1'b1)];
        r_rd_b   <= r_mem[rmxt_pkg::NODE_AW'(i_rd_ptr_b - 1'b1)];
        r_null_a <= (i_rd_ptr_a == '0);
        r_null_b <= (i_rd_ptr_b == '0);
    end

    assign o_rd_word_a = r_null_a ? '0 : r_rd_a;
    assign o_rd_word_b = r_null_b ? '0 : r_rd_b;

endmodule

@@ design/rmxt_root_mem.sv @@
// Root pointer of each trie version, one write and one registered read port.
// Version zero is the empty trie with root zero. Depends on rmxt_pkg.
`timescale 1ns / 1ps

module rmxt_root_mem (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [rmxt_pkg::STORE_W-1:0] i_wr_idx,
    input  logic [rmxt_pkg::PTR_W-1:0]   i_wr_root,
    input  logic [rmxt_pkg::STORE_W-1:0] i_rd_idx,
    output logic [rmxt_pkg::PTR_W-1:0]   o_rd_root
);

    logic [rmxt_pkg::PTR_W-1:0] r_mem [rmxt_pkg::CAPACITY];
    logic [rmxt_pkg::PTR_W-1:0] r_rd;
    logic                       r_zero;

    // Version k lives at address k-1.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[rmxt_pkg::ROOT_AW'(i_wr_idx - 1'b1)] <= i_wr_root;
        end
        r_rd   <= r_mem[rmxt_pkg::ROOT_AW'(i_rd_idx - 1'b1)];
        r_zero <= (i_rd_idx == '0);
    end

    assign o_rd_root = r_zero ? '0 : r_rd;

endmodule

@@ design/rmxt_level_unit.sv @@
// Shared per-level step of the trie walk, used by both append and query.
// Pure logic; depends on rmxt_pkg.
`timescale 1ns / 1ps

module rmxt_level_unit (
    input  logic                       i_query,
    input  logic                       i_bit,
    input  rmxt_pkg::t_node            i_word_a,
    input  rmxt_pkg::t_node            i_word_b,
    input  logic [rmxt_pkg::PTR_W-1:0] i_next_ptr,
    output rmxt_pkg::t_step            o_step
);

    logic                          take;
    logic                          side;
    logic [rmxt_pkg::TALLY_W-1:0]  alt_a;
    logic [rmxt_pkg::TALLY_W-1:0]  alt_b;
    rmxt_pkg::t_node               fresh;

    always_comb begin
        // word_a is the lower version, word_b the upper one
        alt_a = i_bit ? i_word_a.t0 : i_word_a.t1;
        alt_b = i_bit ? i_word_b.t0 : i_word_b.t1;
        take  = i_query && (alt_a != alt_b);
        side  = take ? ~i_bit : i_bit;

        // copy the old node and point the taken side at the next fresh node
        fresh = i_word_a;
        if (i_bit) begin
            fresh.c1 = i_next_ptr;
            fresh.t1 = i_word_a.t1 + 1'b1;
        end else begin
            fresh.c0 = i_next_ptr;
            fresh.t0 = i_word_a.t0 + 1'b1;
        end

        o_step.ptr_a   = side ? i_word_a.c1 : i_word_a.c0;
        o_step.ptr_b   = side ? i_word_b.c1 : i_word_b.c0;
        o_step.res_bit = take;
        o_step.wr_word = fresh;
    end

endmodule

@@ design/range_max_xor_trie.sv @@
// Range max-XOR over a persistent binary trie. An append or a query looks up its
// roots, then takes one trie level per cycle over 31 levels through the shared
// level unit and the node pool read ports; an append then writes its leaf.
// Any other word, or one with a bad status, goes straight to the result.
// One word in flight, taken after the result is loaded.
// Synchronous active-low reset empties the store; no clearing pass.
`timescale 1ns / 1ps

module range_max_xor_trie (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // tdata: value [30:0], range_first [41:31], range_last [52:42], zero fill
    input  logic [rmxt_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // tuser: mode [1:0]
    input  logic [rmxt_pkg::MODE_W-1:0]     i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // tdata: max_xor [30:0], zero fill
    output logic [rmxt_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // tuser: status [1:0]
    output logic [rmxt_pkg::STATUS_W-1:0]   o_m_axis_tuser
);

`include "assert_macros.svh"

    rmxt_pkg::t_state r_state, n_state;

    rmxt_pkg::t_mode                  r_mode;
    logic [rmxt_pkg::VALUE_BITS-1:0]  r_value;
    logic [rmxt_pkg::RANGE_W-1:0]     r_last;
    logic [rmxt_pkg::STORE_W-1:0]     r_stored;
    logic [rmxt_pkg::LEVEL_W-1:0]     r_level;
    logic [rmxt_pkg::PTR_W-1:0]       r_fresh;
    logic [rmxt_pkg::PTR_W-1:0]       r_lo;
    logic [rmxt_pkg::VALUE_BITS-1:0]  r_acc;
    rmxt_pkg::t_status                r_status;
    logic                             r_out_valid;
    logic [rmxt_pkg::VALUE_BITS-1:0]  r_out_data;
    rmxt_pkg::t_status                r_out_status;

    logic                             s_acc;
    logic                             out_load;
    rmxt_pkg::t_mode                  in_mode;
    logic [rmxt_pkg::VALUE_BITS-1:0]  in_value;
    logic [rmxt_pkg::RANGE_W-1:0]     in_first;
    logic [rmxt_pkg::RANGE_W-1:0]     in_last;
    logic                             range_ok;
    logic                             store_full;
    rmxt_pkg::t_status                in_status;
    logic [rmxt_pkg::PTR_W-1:0]       base_top;

    logic                             root_wr_en;
    logic [rmxt_pkg::STORE_W-1:0]     root_rd_idx;
    logic [rmxt_pkg::PTR_W-1:0]       root_rd;
    logic                             node_wr_en;
    rmxt_pkg::t_node                  node_wr_word;
    logic [rmxt_pkg::PTR_W-1:0]       node_rd_a;
    logic [rmxt_pkg::PTR_W-1:0]       node_rd_b;
    rmxt_pkg::t_node                  word_a;
    rmxt_pkg::t_node                  word_b;
    rmxt_pkg::t_step                  step;

    assign in_mode  = rmxt_pkg::t_mode'(i_s_axis_tuser);
    assign in_value = i_s_axis_tdata[rmxt_pkg::VALUE_BITS-1:0];
    assign in_first = i_s_axis_tdata[rmxt_pkg::FIRST_LSB +: rmxt_pkg::RANGE_W];
    assign in_last  = i_s_axis_tdata[rmxt_pkg::LAST_LSB +: rmxt_pkg::RANGE_W];

    assign range_ok = (in_first != '0) && (in_first <= in_last)
                   && (32'(in_last) <= 32'(r_stored));
    assign store_full = (32'(r_stored) >= rmxt_pkg::CAPACITY);
    // first node of the next append; also the root of the new version
    assign base_top = rmxt_pkg::PTR_W'(32'(r_stored) * rmxt_pkg::NODES_PER_VALUE + 1);

    always_comb begin
        case (in_mode)
            rmxt_pkg::MODE_APPEND: in_status = store_full ? rmxt_pkg::STATUS_FULL
                                                          : rmxt_pkg::STATUS_OK;
            rmxt_pkg::MODE_QUERY:  in_status = range_ok ? rmxt_pkg::STATUS_OK
                                                        : rmxt_pkg::STATUS_RANGE;
            default:               in_status = rmxt_pkg::STATUS_OK;
        endcase
    end

    assign s_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign out_load = (r_state == rmxt_pkg::ST_FINISH) && (!r_out_valid || i_m_axis_tready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rmxt_pkg::ST_IDLE: begin
                if (s_acc) begin
                    if (in_status == rmxt_pkg::STATUS_OK &&
                        (in_mode == rmxt_pkg::MODE_APPEND || in_mode == rmxt_pkg::MODE_QUERY))
                        n_state = rmxt_pkg::ST_ROOT_A;
                    else
                        n_state = rmxt_pkg::ST_FINISH;
                end
            end
            rmxt_pkg::ST_ROOT_A: begin
                n_state = (r_mode == rmxt_pkg::MODE_QUERY) ? rmxt_pkg::ST_ROOT_B
                                                           : rmxt_pkg::ST_WALK;
            end
            rmxt_pkg::ST_ROOT_B: n_state = rmxt_pkg::ST_WALK;
            rmxt_pkg::ST_WALK: begin
                if (r_level == '0)
                    n_state = (r_mode == rmxt_pkg::MODE_QUERY) ? rmxt_pkg::ST_FINISH
                                                               : rmxt_pkg::ST_LEAF;
            end
            rmxt_pkg::ST_LEAF:   n_state = rmxt_pkg::ST_FINISH;
            rmxt_pkg::ST_FINISH: if (out_load) n_state = rmxt_pkg::ST_IDLE;
            default:             n_state = rmxt_pkg::ST_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        o_s_axis_tready = 1'b0;
        root_wr_en      = 1'b0;
        root_rd_idx     = '0;
        node_wr_en      = 1'b0;
        node_wr_word    = step.wr_word;
        node_rd_a       = '0;
        node_rd_b       = '0;
        unique case (r_state)
            rmxt_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                // append starts from the newest version, query from version first-1
                root_rd_idx = (in_mode == rmxt_pkg::MODE_APPEND) ? r_stored
                            : rmxt_pkg::STORE_W'(in_first - 1'b1);
            end
            rmxt_pkg::ST_ROOT_A: begin
                root_rd_idx = rmxt_pkg::STORE_W'(r_last);
                node_rd_a   = root_rd;
            end
            rmxt_pkg::ST_ROOT_B: begin
                node_rd_a = r_lo;
                node_rd_b = root_rd;
            end
            rmxt_pkg::ST_WALK: begin
                node_rd_a  = step.ptr_a;
                node_rd_b  = step.ptr_b;
                node_wr_en = (r_mode == rmxt_pkg::MODE_APPEND);
            end
            rmxt_pkg::ST_LEAF: begin
                node_wr_en   = 1'b1;
                node_wr_word = '0;
                root_wr_en   = 1'b1;
            end
            rmxt_pkg::ST_FINISH: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rmxt_pkg::ST_IDLE;
            r_stored    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_acc && in_mode == rmxt_pkg::MODE_CLEAR)
                r_stored <= '0;
            if (r_state == rmxt_pkg::ST_LEAF)
                r_stored <= r_stored + 1'b1;
            if (out_load)
                r_out_valid <= 1'b1;
            else if (i_m_axis_tready)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_mode   <= in_mode;
            r_value  <= in_value;
            r_last   <= in_last;
            r_level  <= rmxt_pkg::LEVEL_W'(rmxt_pkg::VALUE_BITS - 1);
            r_fresh  <= base_top;
            r_acc    <= '0;
            r_status <= in_status;
        end
        if (r_state == rmxt_pkg::ST_ROOT_A)
            r_lo <= root_rd;
        if (r_state == rmxt_pkg::ST_WALK) begin
            r_level        <= r_level - 1'b1;
            r_fresh        <= r_fresh + 1'b1;
            r_acc[r_level] <= step.res_bit;
        end
        if (out_load) begin
            r_out_data   <= r_acc;
            r_out_status <= r_status;
        end
    end

    rmxt_root_mem u_root_mem (
        .i_clk     (i_clk),
        .i_wr_en   (root_wr_en),
        .i_wr_idx  (r_stored + 1'b1),
        .i_wr_root (base_top),
        .i_rd_idx  (root_rd_idx),
        .o_rd_root (root_rd)
    );

    rmxt_node_mem u_node_mem (
        .i_clk       (i_clk),
        .i_wr_en     (node_wr_en),
        .i_wr_ptr    (r_fresh),
        .i_wr_word   (node_wr_word),
        .i_rd_ptr_a  (node_rd_a),
        .i_rd_ptr_b  (node_rd_b),
        .o_rd_word_a (word_a),
        .o_rd_word_b (word_b)
    );

    rmxt_level_unit u_level_unit (
        .i_query    (r_mode == rmxt_pkg::MODE_QUERY),
        .i_bit      (r_value[r_level]),
        .i_word_a   (word_a),
        .i_word_b   (word_b),
        .i_next_ptr (r_fresh + 1'b1),
        .o_step     (step)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = rmxt_pkg::OUT_DATA_W'(r_out_data);
    assign o_m_axis_tuser  = r_out_status;

    `ASSERT_CLK(a_stored_bound, 32'(r_stored) <= rmxt_pkg::CAPACITY,
        "stored count exceeds capacity")
    `ASSERT_IMPL(a_fresh_unread, node_wr_en && r_state == rmxt_pkg::ST_WALK,
        r_fresh > node_rd_a, "append reads a node it is building")
    `ASSERT_IMPL(a_leaf_ptr, r_state == rmxt_pkg::ST_LEAF,
        32'(r_fresh) == (32'(r_stored) + 1) * rmxt_pkg::NODES_PER_VALUE,
        "leaf pointer out of step with stored count")
    `ASSERT_NEXT(a_leaf_count, r_state == rmxt_pkg::ST_LEAF,
        r_stored == $past(r_stored) + 1'b1, "append did not advance stored count")

endmodule
